FILE: hdl/mtrs_pkg.sv
package mtrs_pkg;

    localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;
    localparam logic [31:0] DELTA_16 = 32'he3779b90;
    localparam logic [31:0] DELTA_32 = 32'hc6ef3720;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_KEY0 = 3'd1;
    localparam logic [2:0] REG_KEY1 = 3'd2;
    localparam logic [2:0] REG_KEY2 = 3'd3;
    localparam logic [2:0] REG_KEY3 = 3'd4;

    localparam logic [2:0] MODE_ENC16 = 3'd0;
    localparam logic [2:0] MODE_DEC16 = 3'd1;
    localparam logic [2:0] MODE_ENC32 = 3'd2;
    localparam logic [2:0] MODE_DEC32 = 3'd3;
    localparam logic [2:0] MODE_RC4 = 3'd4;

    typedef struct packed {
        logic       start;
        logic       decrypt;
        logic [5:0] rounds;
    } tea_cmd_t;

    function automatic logic [2:0] mod5(input logic [7:0] b);
        logic [8:0] r;
        begin
            r = {1'b0, b};
            if (r >= 9'd160) r = r - 9'd160;
            if (r >= 9'd80) r = r - 9'd80;
            if (r >= 9'd40) r = r - 9'd40;
            if (r >= 9'd20) r = r - 9'd20;
            if (r >= 9'd10) r = r - 9'd10;
            if (r >= 9'd5) r = r - 9'd5;
            return r[2:0];
        end
    endfunction

endpackage

FILE: hdl/mode_selected_tea_rc4_scrambler_top.sv
// channel  | valid      | ready      | payload
// in       | in_valid   | in_ready   | block_low, block_high
// out      | out_valid  | out_ready  | result_low, result_high
// cfg      | cfg_valid  | cfg_ready  | cfg_index, cfg_data
// tea modes run 16 or 32 rounds on one shared add/sub unit
// rc4 runs a table fill, a key schedule and a 16-byte keystream pass on one table with a read and a write port
// pass-through result is registered and valid in the cycle after accept; in_ready is low from accept until taken
// out stalls hold the result register; reset clears control and config registers
module mode_selected_tea_rc4_scrambler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_low,
    output logic [63:0] result_high,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic enable_reg;
    logic [127:0] key_reg;
    logic busy_reg;
    logic out_valid_reg;
    logic [63:0] rl_reg, rh_reg;
    logic [2:0] mode;
    logic acc;
    mtrs_pkg::tea_cmd_t tcmd;
    logic tdone, rdone;
    logic [63:0] tlo, thi;
    logic [127:0] rres;

    assign acc = in_valid && in_ready;
    assign mode = mtrs_pkg::mod5(block_low[7:0]);
    assign in_ready = !busy_reg && !out_valid_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        tcmd.start = acc && enable_reg && (mode != mtrs_pkg::MODE_RC4);
        tcmd.decrypt = (mode == mtrs_pkg::MODE_DEC16) || (mode == mtrs_pkg::MODE_DEC32);
        tcmd.rounds = ((mode == mtrs_pkg::MODE_ENC32) || (mode == mtrs_pkg::MODE_DEC32))
                      ? 6'd32 : 6'd16;
    end

    mtrs_tea u_tea (
        .clk(clk), .rst_n(rst_n), .cmd(tcmd), .key(key_reg),
        .blk_lo(block_low), .blk_hi(block_high),
        .done(tdone), .res_lo(tlo), .res_hi(thi)
    );

    mtrs_rc4 u_rc4 (
        .clk(clk), .rst_n(rst_n),
        .start(acc && enable_reg && (mode == mtrs_pkg::MODE_RC4)),
        .key(key_reg), .blk({block_high, block_low}),
        .done(rdone), .res(rres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            key_reg <= '0;
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    mtrs_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                    mtrs_pkg::REG_KEY0: key_reg[31:0] <= cfg_data;
                    mtrs_pkg::REG_KEY1: key_reg[63:32] <= cfg_data;
                    mtrs_pkg::REG_KEY2: key_reg[95:64] <= cfg_data;
                    mtrs_pkg::REG_KEY3: key_reg[127:96] <= cfg_data;
                    default: ;
                endcase
            end
            if (acc && enable_reg) busy_reg <= 1'b1;
            else if (tdone || rdone) busy_reg <= 1'b0;
            if ((acc && !enable_reg) || tdone || rdone) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && !enable_reg)
        begin
            rl_reg <= block_low;
            rh_reg <= block_high;
        end
        else if (tdone)
        begin
            rl_reg <= tlo;
            rh_reg <= thi;
        end
        else if (rdone)
        begin
            rl_reg <= rres[63:0];
            rh_reg <= rres[127:64];
        end
    end

    assign out_valid = out_valid_reg;
    assign result_low = rl_reg;
    assign result_high = rh_reg;

endmodule

FILE: hdl/mtrs_tea.sv
module mtrs_tea (
    input  logic                clk,
    input  logic                rst_n,
    input  mtrs_pkg::tea_cmd_t  cmd,
    input  logic [127:0]        key,
    input  logic [63:0]         blk_lo,
    input  logic [63:0]         blk_hi,
    output logic                done,
    output logic [63:0]         res_lo,
    output logic [63:0]         res_hi
);

    logic [31:0] v_reg [4];
    logic [31:0] v_next [4];
    logic [31:0] sum_reg, sum_next;
    logic [1:0] step_reg, step_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic dec_reg, dec_next;
    logic done_reg, done_next;

    logic [31:0] src, dst, ks, f, sum_use;
    logic [1:0] kidx;
    logic [1:0] dsel;
    logic second;

    always_comb
    begin
        second = step_reg[0] ^ dec_reg;
        sum_use = sum_reg;
        if (dec_reg ^ step_reg[0])
            sum_use = sum_reg;
        dsel = {step_reg[1], second};
        src = v_reg[{step_reg[1], ~second}];
        dst = v_reg[dsel];
        kidx = second ? sum_use[12:11] : sum_use[1:0];
        ks = key[32*kidx +: 32];
        f = (src ^ sum_use) + ks + ((src << 4) ^ (src >> 5));
        for (int i = 0; i < 4; i++) v_next[i] = v_reg[i];
        sum_next = sum_reg;
        step_next = step_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        dec_next = dec_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            v_next[0] = blk_lo[31:0];
            v_next[1] = blk_lo[63:32];
            v_next[2] = blk_hi[31:0];
            v_next[3] = blk_hi[63:32];
            dec_next = cmd.decrypt;
            cnt_next = cmd.rounds;
            step_next = 2'd0;
            busy_next = 1'b1;
            if (cmd.decrypt)
                sum_next = (cmd.rounds[5]) ? mtrs_pkg::DELTA_32 : mtrs_pkg::DELTA_16;
            else
                sum_next = '0;
        end
        else if (busy_reg)
        begin
            v_next[dsel] = dec_reg ? dst - f : dst + f;
            step_next = step_reg + 2'd1;
            if (step_reg[0] == 1'b0)
                sum_next = dec_reg ? sum_reg - mtrs_pkg::TEA_DELTA
                                   : sum_reg + mtrs_pkg::TEA_DELTA;
            else
                sum_next = dec_reg ? sum_reg + mtrs_pkg::TEA_DELTA
                                   : sum_reg - mtrs_pkg::TEA_DELTA;
            if (step_reg == 2'd3)
            begin
                sum_next = sum_reg;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    // step order per round: half0 first op, half0 second op, half1 first, half1 second
    // sum moves by delta between ops and back after half0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            cnt_reg <= '0;
            dec_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            cnt_reg <= cnt_next;
            dec_reg <= dec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        for (int i = 0; i < 4; i++) v_reg[i] <= v_next[i];
    end

    assign done = done_reg;
    assign res_lo = {v_reg[1], v_reg[0]};
    assign res_hi = {v_reg[3], v_reg[2]};

endmodule

FILE: hdl/mtrs_rc4.sv
module mtrs_rc4 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [127:0]  key,
    input  logic [127:0]  blk,
    output logic          done,
    output logic [127:0]  res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_KRD = 3'd2;
    localparam logic [2:0] S_KJ = 3'd3;
    localparam logic [2:0] S_KWR = 3'd4;
    localparam logic [2:0] S_GRD = 3'd5;
    localparam logic [2:0] S_GJ = 3'd6;
    localparam logic [2:0] S_GT = 3'd7;

    logic [7:0] mem [256];
    logic [7:0] rd_data;
    logic [7:0] rd_addr;
    logic we;
    logic [7:0] wa;
    logic [7:0] wd;

    logic [2:0] state_reg, state_next;
    logic [8:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] si_reg, si_next;
    logic [1:0] ph_reg, ph_next;
    logic [127:0] blk_reg, blk_next;
    logic done_reg, done_next;
    logic [7:0] kb;
    logic [3:0] bi;

    always_ff @(posedge clk)
    begin
        if (we) mem[wa] <= wd;
        rd_data <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        si_next = si_reg;
        ph_next = ph_reg;
        blk_next = blk_reg;
        done_next = 1'b0;
        we = 1'b0;
        wa = i_reg[7:0];
        wd = i_reg[7:0];
        rd_addr = i_reg[7:0];
        kb = key[8*i_reg[3:0] +: 8];
        bi = i_reg[3:0] - 4'd1;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    blk_next = blk;
                    i_next = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                we = 1'b1;
                i_next = i_reg + 9'd1;
                if (i_reg == 9'd255)
                begin
                    i_next = '0;
                    j_next = '0;
                    state_next = S_KRD;
                end
            end
            S_KRD:
            begin
                rd_addr = i_reg[7:0];
                state_next = S_KJ;
            end
            S_KJ:
            begin
                si_next = rd_data;
                j_next = j_reg + kb + rd_data;
                rd_addr = j_reg + kb + rd_data;
                state_next = S_KWR;
            end
            S_KWR:
            begin
                if (ph_reg == 2'd0)
                begin
                    we = 1'b1;
                    wa = i_reg[7:0];
                    wd = rd_data;
                    ph_next = 2'd1;
                end
                else
                begin
                    we = 1'b1;
                    wa = j_reg;
                    wd = si_reg;
                    ph_next = 2'd0;
                    i_next = i_reg + 9'd1;
                    state_next = S_KRD;
                    if (i_reg == 9'd255)
                    begin
                        i_next = 9'd1;
                        j_next = '0;
                        state_next = S_GRD;
                    end
                end
            end
            S_GRD:
            begin
                rd_addr = i_reg[7:0];
                state_next = S_GJ;
            end
            S_GJ:
            begin
                if (ph_reg == 2'd0)
                begin
                    si_next = rd_data;
                    j_next = j_reg + rd_data;
                    rd_addr = j_reg + rd_data;
                    ph_next = 2'd1;
                end
                else if (ph_reg == 2'd1)
                begin
                    we = 1'b1;
                    wa = i_reg[7:0];
                    wd = rd_data;
                    rd_addr = j_reg;
                    ph_next = 2'd2;
                end
                else
                begin
                    we = 1'b1;
                    wa = j_reg;
                    wd = si_reg;
                    si_next = si_reg + rd_data;
                    ph_next = 2'd0;
                    state_next = S_GT;
                end
            end
            S_GT:
            begin
                if (ph_reg == 2'd0)
                begin
                    rd_addr = si_reg;
                    ph_next = 2'd1;
                end
                else
                begin
                    ph_next = 2'd0;
                    blk_next[8*bi +: 8] = blk_reg[8*bi +: 8] ^ rd_data;
                    i_next = i_reg + 9'd1;
                    state_next = S_GRD;
                    if (i_reg == 9'd16)
                    begin
                        state_next = S_IDLE;
                        done_next = 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg <= '0;
            j_reg <= '0;
            ph_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
            ph_reg <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg <= si_next;
        blk_reg <= blk_next;
    end

    assign done = done_reg;
    assign res = blk_reg;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    class scrambler_scoreboard;
        bit          enabled;
        logic [31:0] key [4];
        logic [63:0] want_low [$];
        logic [63:0] want_high [$];
        int          mismatches;

        function new();
            enabled = 0;
            foreach (key[i]) key[i] = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                mtrs_pkg::REG_ENABLE: enabled = data[0];
                mtrs_pkg::REG_KEY0:   key[0] = data;
                mtrs_pkg::REG_KEY1:   key[1] = data;
                mtrs_pkg::REG_KEY2:   key[2] = data;
                mtrs_pkg::REG_KEY3:   key[3] = data;
                default:    ;
            endcase
        endfunction

        function logic [63:0] tea_half(logic [63:0] half, int rounds, bit dec);
            logic [31:0] v0, v1, acc;
            v0 = half[31:0];
            v1 = half[63:32];
            acc = dec ? mtrs_pkg::TEA_DELTA * rounds : 32'd0;
            for (int r = 0; r < rounds; r++)
            begin
                if (dec)
                begin
                    v1 -= (v0 ^ acc) + key[acc[12:11]] + ((v0 << 4) ^ (v0 >> 5));
                    acc -= mtrs_pkg::TEA_DELTA;
                    v0 -= (v1 ^ acc) + key[acc[1:0]] + ((v1 << 4) ^ (v1 >> 5));
                end
                else
                begin
                    v0 += (v1 ^ acc) + key[acc[1:0]] + ((v1 << 4) ^ (v1 >> 5));
                    acc += mtrs_pkg::TEA_DELTA;
                    v1 += (v0 ^ acc) + key[acc[12:11]] + ((v0 << 4) ^ (v0 >> 5));
                end
            end
            return {v1, v0};
        endfunction

        function logic [127:0] rc4_mask(logic [127:0] blk);
            logic [7:0] perm [256];
            logic [7:0] j, t, kb;
            logic [7:0] k;
            for (int i = 0; i < 256; i++) perm[i] = i[7:0];
            j = 0;
            for (int i = 0; i < 256; i++)
            begin
                kb = key[(i >> 2) & 3][(i & 3) * 8 +: 8];
                j = j + kb + perm[i];
                t = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end
            j = 0;
            for (int i = 0; i < 16; i++)
            begin
                k = 8'(i + 1);
                j = j + perm[k];
                t = perm[k];
                perm[k] = perm[j];
                perm[j] = t;
                t = perm[k] + perm[j];
                blk[i * 8 +: 8] ^= perm[t];
            end
            return blk;
        endfunction

        function void note_block(logic [63:0] lo, logic [63:0] hi);
            logic [2:0] mode;
            logic [127:0] b;
            if (enabled)
            begin
                mode = 3'(lo[7:0] % 5);
                case (mode)
                    mtrs_pkg::MODE_ENC16:
                    begin
                        lo = tea_half(lo, 16, 0);
                        hi = tea_half(hi, 16, 0);
                    end
                    mtrs_pkg::MODE_DEC16:
                    begin
                        lo = tea_half(lo, 16, 1);
                        hi = tea_half(hi, 16, 1);
                    end
                    mtrs_pkg::MODE_ENC32:
                    begin
                        lo = tea_half(lo, 32, 0);
                        hi = tea_half(hi, 32, 0);
                    end
                    mtrs_pkg::MODE_DEC32:
                    begin
                        lo = tea_half(lo, 32, 1);
                        hi = tea_half(hi, 32, 1);
                    end
                    default:
                    begin
                        b = rc4_mask({hi, lo});
                        lo = b[63:0];
                        hi = b[127:64];
                    end
                endcase
            end
            want_low.push_back(lo);
            want_high.push_back(hi);
        endfunction

        function void check_result(logic [63:0] lo, logic [63:0] hi);
            logic [63:0] el, eh;
            if (want_low.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: low %h high %h", lo, hi);
                return;
            end
            el = want_low.pop_front();
            eh = want_high.pop_front();
            if (lo !== el || hi !== eh)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: low %h/%h high %h/%h (expected/actual)",
                             el, lo, eh, hi);
            end
        endfunction

        function int pending();
            return want_low.size();
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [63:0] block_low = '0;
    logic [63:0] block_high = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    scrambler_scoreboard sb = new();
    bit quiet = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int stall_left = 0;

    mode_selected_tea_rc4_scrambler_top u_dut (.*);

    always #6 clk = ~clk;

    // result side: stalls in bursts, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 0;
            hold_left = 4000;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            out_ready <= 0;
        end
        else
            out_ready <= rst_n;
    end

    always @(negedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_low, result_high);

    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        bit hs;
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(negedge clk);
            hs = cfg_ready;
            @(posedge clk);
        end
        while (!hs);
        sb.write_reg(idx, data);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic send_block(logic [63:0] lo, logic [63:0] hi);
        bit hs;
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        block_low <= lo;
        block_high <= hi;
        do
        begin
            @(negedge clk);
            hs = in_ready;
            @(posedge clk);
        end
        while (!hs);
        sb.note_block(lo, hi);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_keys(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                            logic [31:0] k3);
        write_cfg(mtrs_pkg::REG_KEY0, k0);
        write_cfg(mtrs_pkg::REG_KEY1, k1);
        write_cfg(mtrs_pkg::REG_KEY2, k2);
        write_cfg(mtrs_pkg::REG_KEY3, k3);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [63:0] lo;
        int sent;
        sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // disabled: pass-through whatever the mode byte
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h0123_4567_89ab_cd04, 64'hfedc_ba98_7654_3210);
        drain();

        write_cfg(mtrs_pkg::REG_ENABLE, 32'h1);
        for (int m = 0; m < 5; m++)
            send_block({56'h0, 8'(m)}, '0);
        send_block('1, '1);
        send_block({56'hffff_ffff_ffff_ff, 8'hfe}, '1);
        drain();

        set_keys('1, '1, '1, '1);
        for (int m = 0; m < 5; m++)
            send_block({{7{8'hff}}, 8'(250 + m)}, '1);
        send_block({56'h0, 8'hff}, '0);
        drain();

        // out-of-range indexes are ignored
        write_cfg(3'd5, '1);
        write_cfg(3'd6, '0);
        write_cfg(3'd7, 32'h0);
        set_keys(32'h0403_0201, 32'h0807_0605, 32'h0c0b_0a09, 32'h100f_0e0d);
        for (int m = 0; m < 5; m++)
            send_block(rand64() & ~64'hff | 64'(m), rand64());
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_keys($urandom, $urandom, $urandom, $urandom);
                1: set_keys('0, '0, '0, '0);
                2: write_cfg(mtrs_pkg::REG_ENABLE, 32'h0);
                3:
                begin
                    write_cfg(mtrs_pkg::REG_ENABLE,
                              {31'($urandom_range(0, 'h7fff_ffff)), 1'b1});
                    set_keys($urandom, $urandom, $urandom, $urandom);
                end
                4: set_keys('1, $urandom, '0, $urandom);
                default: set_keys($urandom, $urandom, $urandom, $urandom);
            endcase
            for (int n = 0; n < 120; n++)
            begin
                lo = rand64();
                sent++;
                if (sent == 60)
                    hold_req = 1;
                if (sent > 620)
                    quiet = 1;
                send_block(lo, rand64());
            end
            drain();
        end

        in_valid <= 0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/mtrs_pkg.sv
hdl/mtrs_tea.sv
hdl/mtrs_rc4.sv
hdl/mode_selected_tea_rc4_scrambler_top.sv
bench/tb_top.sv
